[design/rc_cell_voltage_drop_model_core_defines.svh]
// assertion macros used by the checker file
`ifndef RC_CELL_VOLTAGE_DROP_MODEL_CORE_DEFINES_SVH
`define RC_CELL_VOLTAGE_DROP_MODEL_CORE_DEFINES_SVH

// same-cycle implication on clk, off during rst
`define RCVD_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("rcvd property failed");

// next-cycle implication on clk, off during rst
`define RCVD_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("rcvd property failed");

`endif

[design/rcvd_pkg.sv]
package rcvd_pkg;

  localparam int MAX_ELEMENTS_DEF = 16;
  localparam logic [31:0] MULT_RESET = 32'h0100_0000;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;
  localparam logic KIND_LOWPASS = 1'b0;

  typedef enum logic [1:0] {
    REG_BASE  = 2'd0,
    REG_MULT  = 2'd1,
    REG_COUNT = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MUL_RZ,
    MUL_ESR,
    MUL_OHM,
    MUL_B,
    MUL_A,
    MUL_TERM
  } mul_sel_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LD_START,
    ST_LD_TAU0,
    ST_LD_DIV,
    ST_LD_DIVQ,
    ST_LD_WRITE,
    ST_ESR,
    ST_ESRQ,
    ST_OHM,
    ST_ACC0,
    ST_BQ,
    ST_WK_RD,
    ST_WK_EVAL,
    ST_WK_DSET,
    ST_WK_DIV,
    ST_WK_CL,
    ST_WK_TM,
    ST_WK_ACC,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic     capture;
    mul_sel_t mul_sel;
    logic     esr_load;
    logic     acc_init;
    logic     b_load;
    logic     tau_mul;
    logic     tau_max;
    logic     tau_div;
    logic     div_load;
    logic     div_src_step;
    logic     div_step;
    logic     write_param;
    logic     k_clear;
    logic     k_inc;
    logic     dc_init;
    logic     dc_add;
    logic     nx_load;
    logic     write_fc;
    logic     term_load;
    logic     acc_add;
    logic     finish;
  } dp_cmd_t;

  typedef struct packed {
    logic is_step;
    logic kind;
    logic r_zero;
    logic tau_zero;
    logic last;
    logic empty;
    logic div_last;
  } dp_stat_t;

endpackage

[design/rcvd_ram.sv]
module rcvd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/rcvd_datapath.sv]
module rcvd_datapath #(
  parameter int MAX_ELEMENTS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  rcvd_pkg::dp_cmd_t cmd,
  output rcvd_pkg::dp_stat_t stat,
  input  logic              command,
  input  logic [3:0]        element_index,
  input  logic [31:0]       element_resistance,
  input  logic [31:0]       element_z,
  input  logic              element_kind,
  input  logic [31:0]       current,
  input  logic [31:0]       time_step,
  input  logic [31:0]       base_resistance,
  input  logic [31:0]       resistance_multiplier,
  input  logic [4:0]        element_count,
  output logic [31:0]       delta_v,
  output logic [31:0]       dc_resistance
);
  import rcvd_pkg::*;

  localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int ACC_W = 42 + $clog2(MAX_ELEMENTS + 1) + 1;
  localparam logic signed [ACC_W-1:0] DROP_MAX = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] DROP_MIN = ACC_W'(-64'sd2147483648);

  logic             is_step;
  logic [IDX_W-1:0] idx;
  logic             idx_ok;
  logic [31:0]      r_in;
  logic [31:0]      z_in;
  logic             kind_in;
  logic [31:0]      cur;
  logic [31:0]      dt;
  logic [31:0]      esr;
  logic [64:0]      prod;
  logic [63:0]      bprod;
  logic signed [ACC_W-1:0] acc;
  logic [32:0]      dc;
  logic [31:0]      tau_w;
  logic [IDX_W-1:0] k;
  logic [31:0]      nx;
  logic             term_neg;
  logic [32:0]      rem;
  logic [31:0]      quo;
  logic [4:0]       cnt;
  logic [32:0]      dvs;
  logic             div_sat;
  logic             div_neg;
  logic [MAX_ELEMENTS-1:0] vld;
  logic             fc_vld;

  logic [64:0] prm_rdata;
  logic [31:0] fc_rdata;
  logic [31:0] prm_res;
  logic [31:0] prm_tau;
  logic        prm_kind;

  logic [32:0] op_a;
  logic [31:0] op_b;
  logic [31:0] curmag;
  logic [31:0] ix;
  logic [31:0] ixmag;
  logic [63:0] ma;
  logic        na;
  logic        nb;
  logic [63:0] m_step;
  logic        neg_step;
  logic [63:0] div_m;
  logic [32:0] div_d;
  logic [33:0] div_t;
  logic        div_ge;
  logic [31:0] q;
  logic [31:0] nxmag;
  logic [31:0] nx_div;
  logic [31:0] nx_sel;
  logic [33:0] v;
  logic [32:0] vmag;
  logic [ACC_W-1:0] term_ext;
  logic [CNT_W-1:0] n_act;
  logic [32:0] dc_sum;

  rcvd_ram #(.WIDTH(65), .DEPTH(MAX_ELEMENTS), .AW(IDX_W)) u_prm_ram (
    .clk   (clk),
    .we    (cmd.write_param && idx_ok),
    .waddr (idx),
    .wdata ({kind_in, tau_w, r_in}),
    .raddr (k),
    .rdata (prm_rdata)
  );

  rcvd_ram #(.WIDTH(32), .DEPTH(MAX_ELEMENTS), .AW(IDX_W)) u_fc_ram (
    .clk   (clk),
    .we    (cmd.write_fc),
    .waddr (k),
    .wdata (nx_sel),
    .raddr (k),
    .rdata (fc_rdata)
  );

  assign prm_res  = prm_rdata[31:0];
  assign prm_tau  = prm_rdata[63:32];
  assign prm_kind = prm_rdata[64];

  always_comb begin
    curmag = cur[31] ? (~cur + 32'd1) : cur;
    ix     = fc_vld ? fc_rdata : 32'd0;
    ixmag  = ix[31] ? (~ix + 32'd1) : ix;

    unique case (cmd.mul_sel)
      MUL_RZ:   begin op_a = {1'b0, r_in};   op_b = z_in; end
      MUL_ESR:  begin op_a = {1'b0, base_resistance}; op_b = resistance_multiplier; end
      MUL_OHM:  begin op_a = {1'b0, curmag}; op_b = esr; end
      MUL_B:    begin op_a = {1'b0, curmag}; op_b = dt; end
      MUL_A:    begin op_a = {1'b0, ixmag};  op_b = prm_tau; end
      MUL_TERM: begin op_a = vmag;           op_b = prm_res; end
      default:  begin op_a = '0;             op_b = '0; end
    endcase

    ma = prod[63:0];
    na = ix[31] && (ma != 64'd0);
    nb = cur[31] && (bprod != 64'd0);
    if (na == nb) begin
      m_step   = ma + bprod;
      neg_step = na;
    end else if (ma >= bprod) begin
      m_step   = ma - bprod;
      neg_step = na;
    end else begin
      m_step   = bprod - ma;
      neg_step = nb;
    end

    div_m = cmd.div_src_step ? m_step : {z_in, 32'd0};
    div_d = cmd.div_src_step ? ({1'b0, prm_tau} + {1'b0, dt}) : {1'b0, r_in};

    div_t  = {rem, quo[31]};
    div_ge = div_t >= {1'b0, dvs};

    q = div_sat ? 32'hFFFF_FFFF : quo;
    if (!div_neg && q > 32'h7FFF_FFFF) begin
      nxmag = 32'h7FFF_FFFF;
    end else if (div_neg && q > 32'h8000_0000) begin
      nxmag = 32'h8000_0000;
    end else begin
      nxmag = q;
    end
    nx_div = div_neg ? (~nxmag + 32'd1) : nxmag;
    nx_sel = (prm_tau == 32'd0 || nxmag > curmag) ? cur : nx_div;

    v = prm_kind ? ({{2{cur[31]}}, cur} - {{2{nx[31]}}, nx}) : {{2{nx[31]}}, nx};
    vmag = v[33] ? 33'(~v + 34'd1) : v[32:0];

    term_ext = {{(ACC_W-41){1'b0}}, prod[64:24]};

    n_act = (32'(element_count) > MAX_ELEMENTS) ? CNT_W'(MAX_ELEMENTS)
                                                : CNT_W'(element_count);
    dc_sum = {1'b0, dc[31:0]} + {1'b0, prm_res};
  end

  assign stat.is_step  = is_step;
  assign stat.kind     = kind_in;
  assign stat.r_zero   = (r_in == 32'd0);
  assign stat.tau_zero = (prm_tau == 32'd0);
  assign stat.last     = ({1'b0, CNT_W'(k)} + (CNT_W+1)'(1)) >= {1'b0, n_act};
  assign stat.empty    = (n_act == '0);
  assign stat.div_last = (cnt == 5'd31);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld           <= '0;
      delta_v       <= '0;
      dc_resistance <= '0;
      dc            <= '0;
    end else begin
      if (cmd.write_param && idx_ok) begin
        vld[idx] <= 1'b0;
      end
      if (cmd.write_fc) begin
        vld[k] <= 1'b1;
      end
      if (cmd.dc_init) begin
        dc <= {1'b0, base_resistance};
      end else if (cmd.dc_add && prm_kind == KIND_LOWPASS && !dc[32]) begin
        dc <= dc_sum;
      end
      if (cmd.finish) begin
        dc_resistance <= dc[32] ? 32'hFFFF_FFFF : dc[31:0];
      end
      if (cmd.finish && is_step) begin
        if (acc > DROP_MAX) begin
          delta_v <= 32'h7FFF_FFFF;
        end else if (acc < DROP_MIN) begin
          delta_v <= 32'h8000_0000;
        end else begin
          delta_v <= acc[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    prod   <= 65'(op_a * op_b);
    fc_vld <= vld[k];
    if (cmd.capture) begin
      is_step <= (command == CMD_STEP);
      idx     <= IDX_W'(element_index);
      idx_ok  <= 32'(element_index) < MAX_ELEMENTS;
      r_in    <= element_resistance;
      z_in    <= element_z;
      kind_in <= element_kind;
      cur     <= current;
      dt      <= time_step;
    end
    if (cmd.esr_load) begin
      esr <= (|prod[64:56]) ? 32'hFFFF_FFFF : prod[55:24];
    end
    if (cmd.acc_init) begin
      acc <= cur[31] ? -$signed(term_ext) : $signed(term_ext);
    end else if (cmd.acc_add) begin
      acc <= term_neg ? acc - $signed(term_ext) : acc + $signed(term_ext);
    end
    if (cmd.b_load) begin
      bprod <= prod[63:0];
    end
    if (cmd.tau_mul) begin
      tau_w <= (|prod[64:48]) ? 32'hFFFF_FFFF : prod[47:16];
    end else if (cmd.tau_max) begin
      tau_w <= 32'hFFFF_FFFF;
    end else if (cmd.tau_div) begin
      tau_w <= q;
    end
    if (cmd.k_clear) begin
      k <= '0;
    end else if (cmd.k_inc) begin
      k <= k + IDX_W'(1);
    end
    if (cmd.div_load) begin
      rem     <= {1'b0, div_m[63:32]};
      quo     <= div_m[31:0];
      cnt     <= '0;
      dvs     <= div_d;
      div_sat <= {1'b0, div_m} >= {div_d, 32'd0};
      div_neg <= cmd.div_src_step && neg_step;
    end else if (cmd.div_step) begin
      rem <= div_ge ? 33'(div_t - {1'b0, dvs}) : div_t[32:0];
      quo <= {quo[30:0], div_ge};
      cnt <= cnt + 5'd1;
    end
    if (cmd.nx_load) begin
      nx <= nx_sel;
    end
    if (cmd.term_load) begin
      term_neg <= v[33];
    end
  end

endmodule

[design/rcvd_ctrl.sv]
module rcvd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               command,
  input  logic               out_stall,
  input  rcvd_pkg::dp_stat_t stat,
  output rcvd_pkg::dp_cmd_t  cmd,
  output logic               in_stall,
  output logic               out_valid
);
  import rcvd_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.mul_sel = MUL_A;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = (command == CMD_STEP) ? ST_ESR : ST_LD_START;
        end
      end
      ST_LD_START: begin
        if (stat.kind == KIND_LOWPASS) begin
          cmd.mul_sel = MUL_RZ;
          state_next  = ST_LD_TAU0;
        end else if (stat.r_zero) begin
          cmd.tau_max = 1'b1;
          state_next  = ST_LD_WRITE;
        end else begin
          cmd.div_load = 1'b1;
          state_next   = ST_LD_DIV;
        end
      end
      ST_LD_TAU0: begin
        cmd.tau_mul = 1'b1;
        state_next  = ST_LD_WRITE;
      end
      ST_LD_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = ST_LD_DIVQ;
        end
      end
      ST_LD_DIVQ: begin
        cmd.tau_div = 1'b1;
        state_next  = ST_LD_WRITE;
      end
      ST_LD_WRITE: begin
        cmd.write_param = 1'b1;
        cmd.k_clear     = 1'b1;
        cmd.dc_init     = 1'b1;
        state_next      = stat.empty ? ST_FIN : ST_WK_RD;
      end
      ST_ESR: begin
        cmd.mul_sel = MUL_ESR;
        state_next  = ST_ESRQ;
      end
      ST_ESRQ: begin
        cmd.esr_load = 1'b1;
        state_next   = ST_OHM;
      end
      ST_OHM: begin
        cmd.mul_sel = MUL_OHM;
        state_next  = ST_ACC0;
      end
      ST_ACC0: begin
        cmd.acc_init = 1'b1;
        cmd.mul_sel  = MUL_B;
        state_next   = ST_BQ;
      end
      ST_BQ: begin
        cmd.b_load  = 1'b1;
        cmd.k_clear = 1'b1;
        cmd.dc_init = 1'b1;
        state_next  = stat.empty ? ST_FIN : ST_WK_RD;
      end
      ST_WK_RD: begin
        state_next = ST_WK_EVAL;
      end
      ST_WK_EVAL: begin
        cmd.dc_add = 1'b1;
        if (!stat.is_step) begin
          if (stat.last) begin
            state_next = ST_FIN;
          end else begin
            cmd.k_inc  = 1'b1;
            state_next = ST_WK_RD;
          end
        end else begin
          state_next = stat.tau_zero ? ST_WK_CL : ST_WK_DSET;
        end
      end
      ST_WK_DSET: begin
        cmd.div_load     = 1'b1;
        cmd.div_src_step = 1'b1;
        state_next       = ST_WK_DIV;
      end
      ST_WK_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = ST_WK_CL;
        end
      end
      ST_WK_CL: begin
        cmd.nx_load  = 1'b1;
        cmd.write_fc = 1'b1;
        state_next   = ST_WK_TM;
      end
      ST_WK_TM: begin
        cmd.mul_sel   = MUL_TERM;
        cmd.term_load = 1'b1;
        state_next    = ST_WK_ACC;
      end
      ST_WK_ACC: begin
        cmd.acc_add = 1'b1;
        if (stat.last) begin
          state_next = ST_FIN;
        end else begin
          cmd.k_inc  = 1'b1;
          state_next = ST_WK_RD;
        end
      end
      ST_FIN: begin
        if (!out_valid || !out_stall) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[design/rc_cell_voltage_drop_model_core.sv]
// a load runs LD_START, LD_TAU0 for kind 0 or LD_DIV, LD_DIVQ (32-step divider) for kind 1
// with nonzero resistance, then LD_WRITE, RD and EVAL per active element and FIN; a step
// runs ESR, ESRQ, OHM, ACC0, BQ, then per element RD, EVAL, DSET and the divider if its
// tau is nonzero, CL, TM, ACC, then FIN; one item at a time: the next item is taken once
// the result sits in the output register; a new result waits in FIN behind a stalled one
// reset: synchronous, clears the config, filtered currents and last drop; slots need loading
module rc_cell_voltage_drop_model_core #(
  parameter int MAX_ELEMENTS = rcvd_pkg::MAX_ELEMENTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [3:0]  element_index,
  input  logic [31:0] element_resistance,
  input  logic [31:0] element_z,
  input  logic        element_kind,
  input  logic [31:0] current,
  input  logic [31:0] time_step,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] delta_v,
  output logic [31:0] dc_resistance,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rcvd_pkg::*;

  logic [31:0] base_resistance;
  logic [31:0] resistance_multiplier;
  logic [4:0]  element_count;
  cfg_reg_t    reg_sel;
  dp_cmd_t     cmd;
  dp_stat_t    stat;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      base_resistance       <= '0;
      resistance_multiplier <= MULT_RESET;
      element_count         <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_BASE:  base_resistance       <= pwdata;
        REG_MULT:  resistance_multiplier <= pwdata;
        REG_COUNT: element_count         <= pwdata[4:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BASE:  prdata = base_resistance;
      REG_MULT:  prdata = resistance_multiplier;
      REG_COUNT: prdata = {27'd0, element_count};
      default:   prdata = '0;
    endcase
  end

  rcvd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .command   (command),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  rcvd_datapath #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_dp (
    .clk                   (clk),
    .rst                   (rst),
    .cmd                   (cmd),
    .stat                  (stat),
    .command               (command),
    .element_index         (element_index),
    .element_resistance    (element_resistance),
    .element_z             (element_z),
    .element_kind          (element_kind),
    .current               (current),
    .time_step             (time_step),
    .base_resistance       (base_resistance),
    .resistance_multiplier (resistance_multiplier),
    .element_count         (element_count),
    .delta_v               (delta_v),
    .dc_resistance         (dc_resistance)
  );

endmodule

[design/rcvd_checker.sv]
`include "rc_cell_voltage_drop_model_core_defines.svh"

module rcvd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] delta_v,
  input logic [31:0] dc_resistance
);

  `RCVD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(delta_v) && $stable(dc_resistance))
  `RCVD_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall && !$rose(out_valid))
  `RCVD_ASSERT_IMPL(a_free_with_result, $fell(in_stall), out_valid)

endmodule

bind rc_cell_voltage_drop_model_core rcvd_checker u_rcvd_checker (.*);

[dv/rc_cell_voltage_drop_model_core_test.sv]
module rc_cell_voltage_drop_model_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rcvd_pkg::*;

  localparam int SLOTS = MAX_ELEMENTS_DEF;
  localparam int CYCLE_LIMIT = 4000000;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_op_t;

  typedef struct {
    row_op_t     op;
    logic        cmd;
    logic [3:0]  idx;
    logic [31:0] res;
    logic [31:0] z;
    logic        kind;
    logic [31:0] cur;
    logic [31:0] dt;
    bit          typed;
    logic [31:0] dv;
    logic [31:0] dc;
  } row_t;

  typedef struct {
    logic [31:0] dv;
    logic [31:0] dc;
  } drop_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid, in_stall, command, element_kind;
  logic [3:0] element_index;
  logic [31:0] element_resistance, element_z, current, time_step;
  logic out_valid, out_stall;
  logic [31:0] delta_v, dc_resistance;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;

  rc_cell_voltage_drop_model_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .element_index(element_index),
    .element_resistance(element_resistance), .element_z(element_z),
    .element_kind(element_kind), .current(current), .time_step(time_step),
    .out_valid(out_valid), .out_stall(out_stall),
    .delta_v(delta_v), .dc_resistance(dc_resistance),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [31:0] base_r, mult_r;
  logic [4:0] count_r;
  logic signed [31:0] filt_i [SLOTS];
  logic [31:0] slot_res [SLOTS];
  logic [31:0] slot_tau [SLOTS];
  logic slot_kind [SLOTS];
  logic [31:0] last_dv;

  drop_t pending_drops[$];
  int errors = 0;
  int n_loads = 0, n_steps = 0, n_results = 0;
  bit quiet = 0;
  bit hold_req = 0;
  int cycles = 0;

  function automatic longint scaled(longint v, logic [31:0] r);
    logic [63:0] mg, m;
    mg = v < 0 ? 64'(-v) : 64'(v);
    m = (mg * {32'b0, r}) >> 24;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic int active_slots();
    return count_r > SLOTS ? SLOTS : int'(count_r);
  endfunction

  function automatic logic [31:0] dc_sum();
    logic [63:0] s;
    s = {32'b0, base_r};
    for (int k = 0; k < active_slots(); k++)
      if (slot_kind[k] == KIND_LOWPASS) s += {32'b0, slot_res[k]};
    return s > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void load_slot(logic [3:0] idx, logic [31:0] r, logic [31:0] z,
                                    logic kind);
    logic [63:0] t;
    if (kind == KIND_LOWPASS) t = ({32'b0, r} * {32'b0, z}) >> 16;
    else if (r == 0) t = 64'hFFFF_FFFF;
    else t = {z, 32'b0} / {32'b0, r};
    if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
    slot_res[idx] = r;
    slot_tau[idx] = t[31:0];
    slot_kind[idx] = kind;
    filt_i[idx] = '0;
  endfunction

  function automatic void step_cell(logic [31:0] cur_in, logic [31:0] dt_in);
    longint cur, acc, ix, a, b, nx;
    logic [63:0] curmag, esr, tau, dt, ma, mb, m, q, nmag;
    bit na, nb, neg;
    cur = longint'(signed'(cur_in));
    dt = {32'b0, dt_in};
    curmag = cur < 0 ? 64'(-cur) : 64'(cur);
    esr = ({32'b0, base_r} * {32'b0, mult_r}) >> 24;
    if (esr > 64'hFFFF_FFFF) esr = 64'hFFFF_FFFF;
    acc = scaled(cur, esr[31:0]);
    for (int k = 0; k < active_slots(); k++) begin
      tau = {32'b0, slot_tau[k]};
      ix = longint'(filt_i[k]);
      if (tau == 0) begin
        nx = cur;
      end else begin
        a = ix * longint'(tau);
        b = cur * longint'(dt);
        na = a < 0;
        nb = b < 0;
        ma = na ? 64'(-a) : 64'(a);
        mb = nb ? 64'(-b) : 64'(b);
        if (na == nb) begin
          m = ma + mb;
          neg = na;
        end else if (ma >= mb) begin
          m = ma - mb;
          neg = na;
        end else begin
          m = mb - ma;
          neg = nb;
        end
        q = m / (tau + dt);
        if (!neg && q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
        if (neg && q > 64'h8000_0000) q = 64'h8000_0000;
        nx = neg ? -longint'(q) : longint'(q);
      end
      nmag = nx < 0 ? 64'(-nx) : 64'(nx);
      if (nmag > curmag) nx = cur;
      filt_i[k] = nx[31:0];
      acc += scaled(slot_kind[k] ? cur - nx : nx, slot_res[k]);
    end
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    last_dv = acc[31:0];
  endfunction

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 65535);
      2: case ($urandom_range(0, 3))
           0: return 32'h0;
           1: return 32'hFFFF_FFFF;
           2: return 32'h7FFF_FFFF;
           default: return 32'h8000_0000;
         endcase
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  task automatic cfg_write(cfg_reg_t which, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {which, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (which)
      REG_BASE: base_r = value;
      REG_MULT: mult_r = value;
      default: count_r = value[4:0];
    endcase
  endtask

  task automatic send_item(logic cmd, logic [3:0] idx, logic [31:0] r, logic [31:0] z,
                           logic kind, logic [31:0] cur, logic [31:0] dt,
                           bit typed, logic [31:0] tdv, logic [31:0] tdc);
    drop_t e;
    if (cmd == CMD_LOAD) begin
      load_slot(idx, r, z, kind);
      n_loads++;
    end else begin
      step_cell(cur, dt);
      n_steps++;
    end
    e.dv = typed ? tdv : last_dv;
    e.dc = typed ? tdc : dc_sum();
    pending_drops.push_back(e);
    in_valid <= 1'b1;
    command <= cmd;
    element_index <= idx;
    element_resistance <= r;
    element_z <= z;
    element_kind <= kind;
    current <= cur;
    time_step <= dt;
    do @(posedge clk); while (in_stall);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_drops.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    drop_t e;
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (pending_drops.size() == 0) begin
        $display("%0t unexpected item: delta_v %h dc_resistance %h", $time, delta_v,
                 dc_resistance);
        errors++;
      end else begin
        e = pending_drops.pop_front();
        if (delta_v !== e.dv) begin
          $display("%0t delta_v expected %h actual %h", $time, e.dv, delta_v);
          errors++;
        end
        if (dc_resistance !== e.dc) begin
          $display("%0t dc_resistance expected %h actual %h", $time, e.dc, dc_resistance);
          errors++;
        end
      end
    end
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  row_t rows [31];

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    command <= CMD_LOAD;
    element_index <= '0;
    element_resistance <= '0;
    element_z <= '0;
    element_kind <= KIND_LOWPASS;
    current <= '0;
    time_step <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    base_r = '0;
    mult_r = MULT_RESET;
    count_r = '0;
    last_dv = '0;
    for (int k = 0; k < SLOTS; k++) begin
      filt_i[k] = '0;
      slot_res[k] = '0;
      slot_tau[k] = '0;
      slot_kind[k] = KIND_LOWPASS;
    end
    rows = '{
      '{ROW_ITEM, CMD_STEP, 0, 0, 0, 0, 32'h7FFF_FFFF, 0, 1, 0, 0},
      '{ROW_ITEM, CMD_STEP, 0, 0, 0, 0, 32'h8000_0000, 32'hFFFF_FFFF, 1, 0, 0},
      // zero tau, zero divisor, saturated taus, one-second taus
      '{ROW_ITEM, CMD_LOAD, 0, 0, 0, 0, 0, 0, 1, 0, 0},
      '{ROW_ITEM, CMD_LOAD, 1, 0, 32'd12345, 1, 0, 0, 1, 0, 0},
      '{ROW_ITEM, CMD_LOAD, 2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 1, 0, 0},
      '{ROW_ITEM, CMD_LOAD, 3, 32'h1, 32'hFFFF_FFFF, 1, 0, 0, 1, 0, 0},
      '{ROW_ITEM, CMD_LOAD, 4, 32'h0100_0000, 32'h100, 0, 0, 0, 1, 0, 0},
      '{ROW_ITEM, CMD_LOAD, 5, 32'h0100_0000, 32'h100, 1, 0, 0, 1, 0, 0},
      '{ROW_ITEM, CMD_LOAD, 6, 32'h0080_0000, 32'h1000, 0, 0, 0, 1, 0, 0},
      '{ROW_ITEM, CMD_LOAD, 7, 32'hFFFF_FFFF, 32'h0, 1, 0, 0, 1, 0, 0},
      '{ROW_ITEM, CMD_LOAD, 8, 32'h0000_1000, 32'h0000_0010, 0, 0, 0, 1, 0, 0},
      '{ROW_ITEM, CMD_LOAD, 9, 32'h0200_0000, 32'h0004_0000, 1, 0, 0, 1, 0, 0},
      '{ROW_ITEM, CMD_LOAD, 10, 32'h0010_0000, 32'h0000_8000, 0, 0, 0, 1, 0, 0},
      '{ROW_ITEM, CMD_LOAD, 11, 32'h8000_0000, 32'h7FFF_FFFF, 1, 0, 0, 1, 0, 0},
      '{ROW_ITEM, CMD_LOAD, 12, 32'h0000_0001, 32'h0000_0001, 0, 0, 0, 1, 0, 0},
      '{ROW_ITEM, CMD_LOAD, 13, 32'h0040_0000, 32'h0000_0400, 1, 0, 0, 1, 0, 0},
      '{ROW_ITEM, CMD_LOAD, 14, 32'h7FFF_FFFF, 32'h0000_0200, 0, 0, 0, 1, 0, 0},
      '{ROW_ITEM, CMD_LOAD, 15, 32'h0300_0000, 32'h0000_0300, 1, 0, 0, 1, 0, 0},
      '{ROW_CFG, 0, REG_BASE, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_CFG, 0, REG_MULT, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_CFG, 0, REG_COUNT, 32'd16, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, CMD_STEP, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0},
      '{ROW_ITEM, CMD_STEP, 0, 0, 0, 0, 32'h8000_0000, 32'h0, 0, 0, 0},
      '{ROW_ITEM, CMD_STEP, 0, 0, 0, 0, 32'h0, 32'h1, 0, 0, 0},
      '{ROW_ITEM, CMD_STEP, 0, 0, 0, 0, 32'h1, 32'h0001_0000, 0, 0, 0},
      '{ROW_ITEM, CMD_STEP, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'h0001_0000, 0, 0, 0},
      // count above the slot total, unity base, zero multiplier
      '{ROW_CFG, 0, REG_COUNT, 32'd31, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_CFG, 0, REG_BASE, 32'h0100_0000, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_CFG, 0, REG_MULT, 32'h0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, CMD_STEP, 0, 0, 0, 0, 32'h0003_0000, 32'h0000_8000, 0, 0, 0},
      '{ROW_ITEM, CMD_STEP, 0, 0, 0, 0, 32'hFFFD_0000, 32'h0002_0000, 0, 0, 0}
    };
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) begin
      if (rows[i].op == ROW_CFG) begin
        drain();
        cfg_write(cfg_reg_t'(rows[i].idx[1:0]), rows[i].res);
      end else begin
        send_item(rows[i].cmd, rows[i].idx, rows[i].res, rows[i].z, rows[i].kind,
                  rows[i].cur, rows[i].dt, rows[i].typed, rows[i].dv, rows[i].dc);
      end
    end
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      quiet = (ph == 9);
      cfg_write(REG_BASE, rnd_val());
      cfg_write(REG_MULT, $urandom_range(0, 1) ? rnd_val() : MULT_RESET);
      if (ph == 3 || ph == 9) cfg_write(REG_COUNT, 32'd16);
      else if (ph == 6) cfg_write(REG_COUNT, 32'd20);
      else cfg_write(REG_COUNT, $urandom_range(0, 5));
      if (ph == 1) hold_req = 1;
      for (int i = 0; i < 128; i++) begin
        if ($urandom_range(0, 3) == 0)
          send_item(CMD_LOAD, 4'($urandom_range(0, 15)), rnd_val(), rnd_val(),
                    1'($urandom_range(0, 1)), rnd_val(), rnd_val(), 0, 0, 0);
        else
          send_item(CMD_STEP, 4'($urandom), $urandom, $urandom, 1'($urandom),
                    rnd_val(), rnd_val(), 0, 0, 0);
      end
      drain();
    end

    repeat (100) @(posedge clk);
    $display("covered %0d loads and %0d steps, %0d results checked", n_loads, n_steps,
             n_results);
    $display("register extremes, counts 0..31, long output hold and input gaps exercised");
    if (errors == 0 && pending_drops.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/rcvd_pkg.sv
design/rcvd_ram.sv
design/rcvd_datapath.sv
design/rcvd_ctrl.sv
design/rc_cell_voltage_drop_model_core.sv
design/rcvd_checker.sv
dv/rc_cell_voltage_drop_model_core_test.sv
